// ===== design/shading_fresnel_geometry_factor_macros.svh =====
// ----------------------------------------------------------------------------
// Shading factor unit assertion macros
// Concurrent checks clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SHADING_FRESNEL_GEOMETRY_FACTOR_MACROS_SVH
`define SHADING_FRESNEL_GEOMETRY_FACTOR_MACROS_SVH

// same-cycle implication
`define SFG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sfg_pkg.sv =====
// ----------------------------------------------------------------------------
// Shading factor package
// Fixed-point formats, Q30 constants, side-band type and Q30 multiply helper.
// ----------------------------------------------------------------------------
`default_nettype none

package sfg_pkg;

    localparam int FRAC_BITS = 14;
    localparam int Q_SHIFT   = 30 - FRAC_BITS;
    localparam int SQ_SHIFT  = 2 * Q_SHIFT - 30;
    localparam int T_W       = FRAC_BITS + 1;
    localparam int FIELD_W   = 15;
    localparam int COS_W     = 16;
    localparam int EPS_W     = 11;
    localparam int DIV_STEPS = 15;
    localparam int NUM_W     = 61;
    localparam int DEN_W     = 31;
    localparam int LANES     = 2;
    localparam int LANE_F    = 0;
    localparam int LANE_G    = 1;

    localparam logic [T_W-1:0] ONE = T_W'(1 << FRAC_BITS);
    localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

    localparam logic OP_SPECULAR = 1'b0;
    localparam logic OP_GEOM     = 1'b1;

    // Q30 constants
    localparam longint unsigned Q30_ONE = 64'd1 << 30;
    localparam longint unsigned KF_Q30  = 64'd1202590843;
    localparam longint unsigned KG_Q30  = 64'd1084479242;
    localparam longint unsigned KF2     = (KF_Q30 * KF_Q30) >> 30;
    localparam longint unsigned MF      = KF_Q30 - Q30_ONE;
    localparam longint unsigned AF      = (MF * MF) >> 30;
    localparam longint unsigned KF2_A   = KF2 - AF;
    localparam longint unsigned KG2     = (KG_Q30 * KG_Q30) >> 30;
    localparam longint unsigned MG      = KG_Q30 - Q30_ONE;
    localparam longint unsigned CG      = (MG * MG) >> 30;
    localparam longint unsigned KG2_C   = KG2 - CG;

    // cosine polynomial, Horner form in y = x^2
    localparam logic signed [31:0] P_INIT = -32'sd27060;
    localparam logic signed [31:0] HORNER_C [4] = '{
        32'sd987048, -32'sd22401992, 32'sd272375558, -32'sd1324675879
    };
    localparam logic signed [32:0] COS_ONE = 33'sd1073741824;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_FIXED   = 2'd0;
    localparam t_mode MODE_FRESNEL = 2'd1;
    localparam t_mode MODE_GEOM    = 2'd2;

    typedef struct packed {
        t_mode              mode;
        logic               fix_factor;
        logic               fix_fresnel;
        logic               inc_ok;
        logic [FIELD_W-1:0] inc;
    } t_side;

    // sign-magnitude product, truncated toward zero
    function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                   input logic [30:0] y);
        logic [31:0] mag;
        logic [61:0] prod;
        logic [31:0] r;
        mag  = a[31] ? 32'(-a) : 32'(a);
        prod = 62'(mag[30:0]) * 62'(y);
        r    = prod[61:30];
        return a[31] ? -signed'(r) : signed'(r);
    endfunction

endpackage

`default_nettype wire

// ===== design/sfg_angle_step.sv =====
// ----------------------------------------------------------------------------
// Angle search step
// One bit of the MSB-first angle search: evaluates the cosine polynomial at
// the candidate over six register stages and keeps the bit when it holds.
// ----------------------------------------------------------------------------
`default_nettype none

module sfg_angle_step (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_adv,
    input  logic [sfg_pkg::T_W-1:0]            i_mask,
    input  logic                               i_vld,
    input  sfg_pkg::t_side                     i_side,
    input  logic signed [sfg_pkg::COS_W-1:0]   i_cos,
    input  logic [sfg_pkg::T_W-1:0]            i_t,
    output logic                               o_vld,
    output sfg_pkg::t_side                     o_side,
    output logic signed [sfg_pkg::COS_W-1:0]   o_cos,
    output logic [sfg_pkg::T_W-1:0]            o_t
);
    import sfg_pkg::*;

    localparam int NS = 5;

    logic                    r_vld  [NS];
    t_side                   r_side [NS];
    logic signed [COS_W-1:0] r_cos  [NS];
    logic [T_W-1:0]          r_t    [NS];
    logic [T_W-1:0]          r_cand [NS];
    logic                    r_ok   [NS];
    logic [30:0]             r_y    [NS];
    logic signed [31:0]      r_p    [NS];

    logic                    r_ovld;
    t_side                   r_oside;
    logic signed [COS_W-1:0] r_ocos;
    logic [T_W-1:0]          r_ot;

    logic [T_W-1:0]          w_cand;
    logic [2*T_W-1:0]        w_sq;
    logic [30:0]             w_y;
    logic signed [31:0]      w_fin;
    logic signed [32:0]      w_cosv;
    logic signed [32:0]      w_c30;
    logic                    w_take;

    always_comb begin
        w_cand = i_t | i_mask;
        w_sq   = (2*T_W)'(w_cand) * (2*T_W)'(w_cand);
        w_y    = 31'(62'(w_sq) << SQ_SHIFT);
        w_fin  = mul_q30(r_p[NS-1], r_y[NS-1]);
        w_cosv = COS_ONE + 33'(w_fin);
        w_c30  = 33'(r_cos[NS-1]) <<< Q_SHIFT;
        w_take = r_ok[NS-1] && (w_cosv >= w_c30);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_ovld <= 1'b0;
        end else if (i_adv) begin
            r_vld[0] <= i_vld;
            for (int k = 1; k < NS; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_ovld <= r_vld[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_side[0] <= i_side;
            r_cos[0]  <= i_cos;
            r_t[0]    <= i_t;
            r_cand[0] <= w_cand;
            r_ok[0]   <= (w_cand <= ONE);
            r_y[0]    <= w_y;
            r_p[0]    <= P_INIT;
            for (int k = 1; k < NS; k++) begin
                r_side[k] <= r_side[k-1];
                r_cos[k]  <= r_cos[k-1];
                r_t[k]    <= r_t[k-1];
                r_cand[k] <= r_cand[k-1];
                r_ok[k]   <= r_ok[k-1];
                r_y[k]    <= r_y[k-1];
                r_p[k]    <= HORNER_C[k-1] + mul_q30(r_p[k-1], r_y[k-1]);
            end
            r_oside <= r_side[NS-1];
            r_ocos  <= r_cos[NS-1];
            r_ot    <= w_take ? r_cand[NS-1] : r_t[NS-1];
        end
    end

    assign o_vld  = r_ovld;
    assign o_side = r_oside;
    assign o_cos  = r_ocos;
    assign o_t    = r_ot;

endmodule

`default_nettype wire

// ===== design/sfg_div.sv =====
// ----------------------------------------------------------------------------
// Ratio divider
// Two-lane pipelined restoring divider: quotient of num / (den << Q_SHIFT),
// one quotient bit per stage, with an overflow flag for large quotients.
// ----------------------------------------------------------------------------
`default_nettype none

module sfg_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic                         i_vld,
    input  sfg_pkg::t_side               i_side,
    input  logic [sfg_pkg::NUM_W-1:0]    i_num [sfg_pkg::LANES],
    input  logic [sfg_pkg::DEN_W-1:0]    i_den [sfg_pkg::LANES],
    output logic                         o_vld,
    output sfg_pkg::t_side               o_side,
    output logic [sfg_pkg::DIV_STEPS-1:0] o_q  [sfg_pkg::LANES],
    output logic                         o_ovf [sfg_pkg::LANES]
);
    import sfg_pkg::*;

    localparam int NS = DIV_STEPS + 1;

    logic                 r_vld  [NS];
    t_side                r_side [NS];
    logic [NUM_W-1:0]     r_rem  [LANES][NS];
    logic [DEN_W-1:0]     r_den  [LANES][NS];
    logic [DIV_STEPS-1:0] r_q    [LANES][NS];
    logic                 r_ovf  [LANES][NS];

    logic [DEN_W-1:0]     w_den0 [LANES];
    logic [NUM_W:0]       w_sub  [LANES][1:DIV_STEPS];
    logic                 w_ge   [LANES][1:DIV_STEPS];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_den0[l] = (i_den[l] == '0) ? DEN_W'(1) : i_den[l];
            for (int s = 1; s <= DIV_STEPS; s++) begin
                w_sub[l][s] = (NUM_W+1)'(r_den[l][s-1]) << (Q_SHIFT + DIV_STEPS - s);
                w_ge[l][s]  = (NUM_W+1)'(r_rem[l][s-1]) >= w_sub[l][s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (i_adv) begin
            r_vld[0] <= i_vld;
            for (int s = 1; s < NS; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_side[0] <= i_side;
            for (int s = 1; s < NS; s++) begin
                r_side[s] <= r_side[s-1];
            end
            for (int l = 0; l < LANES; l++) begin
                // quotient of 2^DIV_STEPS or more sets the overflow flag
                r_rem[l][0] <= i_num[l];
                r_den[l][0] <= w_den0[l];
                r_q[l][0]   <= '0;
                r_ovf[l][0] <= (NUM_W+1)'(i_num[l]) >=
                               ((NUM_W+1)'(w_den0[l]) << (Q_SHIFT + DIV_STEPS));
                for (int s = 1; s < NS; s++) begin
                    r_den[l][s] <= r_den[l][s-1];
                    r_ovf[l][s] <= r_ovf[l][s-1];
                    if (w_ge[l][s]) begin
                        r_rem[l][s] <= NUM_W'((NUM_W+1)'(r_rem[l][s-1]) - w_sub[l][s]);
                        r_q[l][s]   <= r_q[l][s-1] |
                                       (DIV_STEPS'(1) << (DIV_STEPS - s));
                    end else begin
                        r_rem[l][s] <= r_rem[l][s-1];
                        r_q[l][s]   <= r_q[l][s-1];
                    end
                end
            end
        end
    end

    assign o_vld  = r_vld[NS-1];
    assign o_side = r_side[NS-1];
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_q[l]   = r_q[l][NS-1];
            o_ovf[l] = r_ovf[l][NS-1];
        end
    end

endmodule

`default_nettype wire

// ===== design/shading_fresnel_geometry_factor.sv =====
// ----------------------------------------------------------------------------
// Fresnel and geometric shading factor unit
// Computes the Fresnel term, the geometric term and the specular factor from
// a cosine in Q2.14, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one item per clock while not stalled and returns one result per item,
// in order, through one front stage, a 15-step angle search of six
// stages each (the cosine polynomial is five chained multiplies after the
// candidate square), four stages of Fresnel and geometric ratio terms, a
// 16-stage two-lane divider and three output stages. The whole pipeline holds
// while the output item is stalled. Write epsilon only while no item is in flight.
`default_nettype none

module shading_fresnel_geometry_factor (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [sfg_pkg::EPS_W-1:0]          i_cfg_wr_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_opcode,
    input  logic signed [sfg_pkg::COS_W-1:0]   i_cosine_value,
    input  logic [sfg_pkg::FIELD_W-1:0]        i_incidence,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [sfg_pkg::FIELD_W-1:0]        o_factor,
    output logic [sfg_pkg::FIELD_W-1:0]        o_fresnel_out
);
    import sfg_pkg::*;

    `include "shading_fresnel_geometry_factor_macros.svh"

    logic                    r_epsilon_vld;
    logic [EPS_W-1:0]        r_epsilon;
    logic                    w_adv;

    // front stage
    logic signed [17:0]      w_c;
    logic signed [17:0]      w_eps;
    logic signed [17:0]      w_hi;
    logic                    w_lo_hit;
    logic                    w_hi_hit;
    t_side                   w_side;
    logic                    r0_vld;
    t_side                   r0_side;
    logic signed [COS_W-1:0] r0_cos;

    // angle chain
    logic                    w_ch_vld  [T_W+1];
    t_side                   w_ch_side [T_W+1];
    logic signed [COS_W-1:0] w_ch_cos  [T_W+1];
    logic [T_W-1:0]          w_ch_t    [T_W+1];

    // ratio terms
    logic                    r1_vld, r2_vld, r3_vld, r4_vld;
    t_side                   r1_side, r2_side, r3_side, r4_side;
    logic [DEN_W-1:0]        r1_d, r1_e, r2_d2, r2_e2, r3_d2, r3_e2, r3_df, r3_dg;
    logic [61:0]             w_dd, w_ee, w_nf, w_pf, w_ng, w_pg;
    logic [NUM_W-1:0]        r4_num [LANES];
    logic [DEN_W-1:0]        r4_den [LANES];

    // divider
    logic                    w_dv_vld;
    t_side                   w_dv_side;
    logic [DIV_STEPS-1:0]    w_dv_q   [LANES];
    logic                    w_dv_ovf [LANES];

    // finish and product
    logic [T_W-1:0]          w_fin [LANES];
    logic                    r5_vld, r6_vld;
    t_side                   r5_side, r6_side;
    logic [T_W-1:0]          r5_f, r5_g, r6_f, r6_g;
    logic [29:0]             w_p, w_fac;
    logic [FIELD_W-1:0]      r6_p;

    // output
    logic                    r_o_vld;
    t_mode                   r_o_mode;
    logic [FIELD_W-1:0]      r_o_factor;
    logic [FIELD_W-1:0]      r_o_fresnel;

    assign w_adv   = !r_o_vld || !i_stall;
    assign o_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epsilon     <= EPS_RESET;
            r_epsilon_vld <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_epsilon     <= i_cfg_wr_data;
            r_epsilon_vld <= 1'b1;
        end
    end

    // classify the item: clamped cases travel as fixed results
    always_comb begin
        w_c      = 18'(i_cosine_value);
        w_eps    = signed'(18'(r_epsilon));
        w_hi     = signed'(18'(ONE)) - w_eps;
        w_lo_hit = w_c < w_eps;
        w_hi_hit = w_c > w_hi;
        w_side.inc         = i_incidence;
        w_side.inc_ok      = i_incidence >= FIELD_W'(r_epsilon);
        w_side.fix_factor  = 1'b0;
        w_side.fix_fresnel = 1'b0;
        w_side.mode        = MODE_FIXED;
        if (i_opcode == OP_SPECULAR) begin
            if (w_lo_hit) begin
                w_side.fix_fresnel = 1'b1;
            end else if (!w_hi_hit) begin
                w_side.mode = MODE_FRESNEL;
            end
        end else begin
            if (w_hi_hit) begin
                w_side.fix_factor = 1'b1;
            end else if (!w_lo_hit) begin
                w_side.mode = MODE_GEOM;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (w_adv) begin
            r0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_side <= w_side;
            r0_cos  <= i_cosine_value;
        end
    end

    assign w_ch_vld[0]  = r0_vld;
    assign w_ch_side[0] = r0_side;
    assign w_ch_cos[0]  = r0_cos;
    assign w_ch_t[0]    = '0;

    for (genvar g = 0; g < T_W; g++) begin : g_angle
        sfg_angle_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_mask  (T_W'(1) << (FRAC_BITS - g)),
            .i_vld   (w_ch_vld[g]),
            .i_side  (w_ch_side[g]),
            .i_cos   (w_ch_cos[g]),
            .i_t     (w_ch_t[g]),
            .o_vld   (w_ch_vld[g+1]),
            .o_side  (w_ch_side[g+1]),
            .o_cos   (w_ch_cos[g+1]),
            .o_t     (w_ch_t[g+1])
        );
    end

    always_comb begin
        w_dd = 62'(r1_d) * 62'(r1_d);
        w_ee = 62'(r1_e) * 62'(r1_e);
        w_nf = 62'(r3_df) * 62'(AF);
        w_pf = 62'(r3_d2) * 62'(KF2_A);
        w_ng = 62'(r3_dg) * 62'(KG2);
        w_pg = 62'(r3_e2) * 62'(KG2_C);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld <= w_ch_vld[T_W];
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_side <= w_ch_side[T_W];
            r1_d    <= DEN_W'(KF_Q30) - {w_ch_t[T_W], {Q_SHIFT{1'b0}}};
            r1_e    <= DEN_W'(KG_Q30) - {w_ch_t[T_W], {Q_SHIFT{1'b0}}};
            r2_side <= r1_side;
            r2_d2   <= w_dd[60:30];
            r2_e2   <= w_ee[60:30];
            r3_side <= r2_side;
            r3_d2   <= r2_d2;
            r3_e2   <= r2_e2;
            r3_df   <= (DEN_W'(KF2) > r2_d2) ? DEN_W'(KF2) - r2_d2 : '0;
            r3_dg   <= (r2_e2 > DEN_W'(CG)) ? r2_e2 - DEN_W'(CG) : '0;
            r4_side <= r3_side;
            r4_num[LANE_F] <= w_nf[NUM_W-1:0];
            r4_den[LANE_F] <= w_pf[60:30];
            r4_num[LANE_G] <= w_ng[NUM_W-1:0];
            r4_den[LANE_G] <= w_pg[60:30];
        end
    end

    sfg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_vld   (r4_vld),
        .i_side  (r4_side),
        .i_num   (r4_num),
        .i_den   (r4_den),
        .o_vld   (w_dv_vld),
        .o_side  (w_dv_side),
        .o_q     (w_dv_q),
        .o_ovf   (w_dv_ovf)
    );

    // clamp to one, drop below epsilon
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (w_dv_ovf[l] || (T_W'(w_dv_q[l]) > ONE)) begin
                w_fin[l] = ONE;
            end else begin
                w_fin[l] = T_W'(w_dv_q[l]);
            end
            if (w_fin[l] < T_W'(r_epsilon)) begin
                w_fin[l] = '0;
            end
        end
        w_p   = 30'(r5_f) * 30'(r5_side.inc);
        w_fac = 30'(r6_p) * 30'(r6_g);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld  <= 1'b0;
            r6_vld  <= 1'b0;
            r_o_vld <= 1'b0;
        end else if (w_adv) begin
            r5_vld  <= w_dv_vld;
            r6_vld  <= r5_vld;
            r_o_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_side  <= w_dv_side;
            r5_f     <= w_fin[LANE_F];
            r5_g     <= w_fin[LANE_G];
            r6_side  <= r5_side;
            r6_f     <= r5_f;
            r6_g     <= r5_g;
            r6_p     <= w_p[FRAC_BITS +: FIELD_W];
            r_o_mode <= r6_side.mode;
            case (r6_side.mode)
                MODE_FRESNEL: begin
                    r_o_factor  <= r6_side.inc_ok ? w_fac[FRAC_BITS +: FIELD_W] : '0;
                    r_o_fresnel <= FIELD_W'(r6_f);
                end
                MODE_GEOM: begin
                    r_o_factor  <= FIELD_W'(r6_g);
                    r_o_fresnel <= '0;
                end
                default: begin
                    r_o_factor  <= r6_side.fix_factor ? FIELD_W'(ONE) : '0;
                    r_o_fresnel <= r6_side.fix_fresnel ? FIELD_W'(ONE) : '0;
                end
            endcase
        end
    end

    assign o_valid       = r_o_vld;
    assign o_factor      = r_o_factor;
    assign o_fresnel_out = r_o_fresnel;

    `SFG_ASSERT_IMP(a_no_stall_when_empty, !r_o_vld, !o_stall, "stall with empty output stage")
    `SFG_ASSERT_NXT(a_accept_lands, i_valid && !o_stall, r0_vld, "accepted item lost at front")
    `SFG_ASSERT_IMP(a_fresnel_range, r_o_vld, o_fresnel_out <= FIELD_W'(ONE), "fresnel above one")
    `SFG_ASSERT_IMP(a_geom_no_fresnel, r_o_vld && (r_o_mode == MODE_GEOM), o_fresnel_out == '0, "fresnel set on geometric item")
    `SFG_ASSERT_NXT(a_cfg_taken, i_cfg_wr_en, r_epsilon_vld && (r_epsilon == $past(i_cfg_wr_data)), "epsilon write lost")

endmodule

`default_nettype wire
